/* sv/fac_pkg.sv */
// Shared types, widths and register map of the fuzzy alignment controller.
// No dependencies; every other file in sv/ refers to it by scoped names.
`timescale 1ns / 1ps

package fac_pkg;

    // Rule base
    localparam int NUM_SETS  = 7;
    localparam int FRAC_BITS = 14;
    localparam int HALF_SETS = (NUM_SETS - 1) / 2;
    localparam int SET_CNT   = 2 * HALF_SETS + 1;

    // Field widths
    localparam int CFG_W   = 10;            // pixel registers
    localparam int SPD_W   = 15;            // Q1.14 magnitude registers
    localparam int X_W     = 16;            // input offset
    localparam int RATE_W  = 16;            // output rate
    localparam int COORD_W = CFG_W + 1;     // clamped offset, signed

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int SPD_MAX = (1 << SPD_W) - 1;

    // Datapath widths
    localparam int DIST_W = $clog2((HALF_SETS + 1) * CFG_MAX + 1);
    localparam int SD_W   = DIST_W + 1;
    localparam int W_W    = CFG_W;
    localparam int PROD_W = W_W + SPD_W;
    localparam int SIDE_W = PROD_W + $clog2(HALF_SETS + 1);
    localparam int DEN_W  = $clog2(SET_CNT * CFG_MAX + 1);

    // Divider: quotient is a weighted mean of SPD_W-bit magnitudes
    localparam int Q_W        = SPD_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    // Register port
    localparam int REG_CNT   = 8;
    localparam int REG_IDX_W = $clog2(REG_CNT);
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INPUT_LIMIT,
        REG_DEAD_ZONE,
        REG_TRI_HALF,
        REG_CENTER_STEP,
        REG_OUT_SMALL,
        REG_OUT_MEDIUM,
        REG_OUT_BIG,
        REG_MAX_SPEED
    } reg_idx_t;

    function automatic longint sat_spd(input longint v);
        return (v > SPD_MAX) ? longint'(SPD_MAX) : v;
    endfunction

    function automatic longint scaled_pct(input longint p);
        return ((p << FRAC_BITS) + 50) / 100;
    endfunction

    typedef struct packed {
        logic [CFG_W-1:0] input_limit;
        logic [CFG_W-1:0] dead_zone;
        logic [CFG_W-1:0] tri_half;
        logic [CFG_W-1:0] center_step;
        logic [SPD_W-1:0] out_small;
        logic [SPD_W-1:0] out_medium;
        logic [SPD_W-1:0] out_big;
        logic [SPD_W-1:0] max_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        input_limit: CFG_W'(160),
        dead_zone:   CFG_W'(15),
        tri_half:    CFG_W'(40),
        center_step: CFG_W'(40),
        out_small:   SPD_W'(sat_spd(scaled_pct(15))),
        out_medium:  SPD_W'(sat_spd(scaled_pct(30))),
        out_big:     SPD_W'(sat_spd(scaled_pct(50))),
        max_speed:   SPD_W'(sat_spd(scaled_pct(100)))
    };

    // Membership weights, one per set, lowest centre first
    typedef struct packed {
        logic [SET_CNT-1:0][W_W-1:0] w;
        logic                        aligned;
    } wt_t;

    // Weighted sum magnitude and weight total
    typedef struct packed {
        logic [SIDE_W-1:0] mag;
        logic [DEN_W-1:0]  den;
        logic              neg;
        logic              zero;
        logic              aligned;
    } acc_t;

    // One divider stage
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quo;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             zero;
        logic             aligned;
    } div_t;

endpackage

/* sv/fuzzy_alignment_controller_top.sv */
// Channel    | Dir | Handshake                | Word contents (low bit up)
// s_axis     | in  | tvalid/tready            | tdata[15:0] x_offset, signed pixels
// m_axis     | out | tvalid/tready            | tdata[15:0] angular_rate Q2.14; tuser[0] aligned
// apb        | in  | psel/penable/pwrite      | 8 registers at 4*i, data 32 bits
//
// One word per cycle in and out while m_axis_tready is high; stages: clamp, weights, products,
// side sums, difference, five divider stages of three quotient bits each,
// output register. The divider sets the depth.
// rst_n clears valid bits asynchronously and loads register defaults.
// Each stage holds when the one after it is full and stalled; bubbles fill.
// Depends on fac_pkg, fac_regs, fac_weights, fac_accum and fac_divider.
`timescale 1ns / 1ps

module fuzzy_alignment_controller_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    // tdata: x_offset[15:0]
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,
    // tdata: angular_rate[15:0]; tuser: aligned[0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,
    output logic [0:0]                  m_axis_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fac_pkg::ADDR_W-1:0]  paddr,
    input  logic [fac_pkg::DATA_W-1:0]  pwdata,
    output logic [fac_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    fac_pkg::cfg_t cfg;
    fac_pkg::wt_t  wt_data;
    fac_pkg::acc_t acc_data;
    logic          wt_valid;
    logic          wt_ready;
    logic          acc_valid;
    logic          acc_ready;

    logic signed [fac_pkg::RATE_W-1:0] rate;
    logic                              aligned;

    assign m_axis_tdata = rate;
    assign m_axis_tuser = aligned;

    fac_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fac_weights u_weights
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      ($signed(s_axis_tdata)),
        .out_valid (wt_valid),
        .out_ready (wt_ready),
        .out_data  (wt_data)
    );

    fac_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (wt_valid),
        .in_ready  (wt_ready),
        .in_data   (wt_data),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_data  (acc_data)
    );

    fac_divider u_divider
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (acc_valid),
        .in_ready    (acc_ready),
        .in_data     (acc_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_rate    (rate),
        .out_aligned (aligned)
    );

endmodule

/* sv/fac_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on fac_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module fac_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fac_pkg::ADDR_W-1:0]   paddr,
    input  logic [fac_pkg::DATA_W-1:0]   pwdata,
    output logic [fac_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output fac_pkg::cfg_t                cfg
);

    fac_pkg::cfg_t     cfg_reg;
    fac_pkg::cfg_t     cfg_next;
    fac_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = fac_pkg::reg_idx_t'(paddr[fac_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                fac_pkg::REG_INPUT_LIMIT: cfg_next.input_limit = pwdata[fac_pkg::CFG_W-1:0];
                fac_pkg::REG_DEAD_ZONE:   cfg_next.dead_zone   = pwdata[fac_pkg::CFG_W-1:0];
                fac_pkg::REG_TRI_HALF:    cfg_next.tri_half    = pwdata[fac_pkg::CFG_W-1:0];
                fac_pkg::REG_CENTER_STEP: cfg_next.center_step = pwdata[fac_pkg::CFG_W-1:0];
                fac_pkg::REG_OUT_SMALL:   cfg_next.out_small   = pwdata[fac_pkg::SPD_W-1:0];
                fac_pkg::REG_OUT_MEDIUM:  cfg_next.out_medium  = pwdata[fac_pkg::SPD_W-1:0];
                fac_pkg::REG_OUT_BIG:     cfg_next.out_big     = pwdata[fac_pkg::SPD_W-1:0];
                fac_pkg::REG_MAX_SPEED:   cfg_next.max_speed   = pwdata[fac_pkg::SPD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= fac_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            fac_pkg::REG_INPUT_LIMIT: prdata = fac_pkg::DATA_W'(cfg_reg.input_limit);
            fac_pkg::REG_DEAD_ZONE:   prdata = fac_pkg::DATA_W'(cfg_reg.dead_zone);
            fac_pkg::REG_TRI_HALF:    prdata = fac_pkg::DATA_W'(cfg_reg.tri_half);
            fac_pkg::REG_CENTER_STEP: prdata = fac_pkg::DATA_W'(cfg_reg.center_step);
            fac_pkg::REG_OUT_SMALL:   prdata = fac_pkg::DATA_W'(cfg_reg.out_small);
            fac_pkg::REG_OUT_MEDIUM:  prdata = fac_pkg::DATA_W'(cfg_reg.out_medium);
            fac_pkg::REG_OUT_BIG:     prdata = fac_pkg::DATA_W'(cfg_reg.out_big);
            fac_pkg::REG_MAX_SPEED:   prdata = fac_pkg::DATA_W'(cfg_reg.max_speed);
        endcase
    end

endmodule

/* sv/fac_weights.sv */
// Front pipeline: offset clamp, dead zone test, then triangular memberships.
// Two register stages; depends on fac_pkg.
`timescale 1ns / 1ps

module fac_weights
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fac_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [fac_pkg::X_W-1:0]    in_x,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fac_pkg::wt_t                      out_data
);

    logic [1:0] valid_reg;
    logic [2:0] rdy;

    logic signed [fac_pkg::COORD_W-1:0] x_reg;
    logic signed [fac_pkg::COORD_W-1:0] x_next;
    logic                               aligned_reg;
    logic                               aligned_next;
    fac_pkg::wt_t                       wt_reg;
    fac_pkg::wt_t                       wt_next;

    assign rdy[2]    = out_ready;
    assign rdy[1]    = !valid_reg[1] || rdy[2];
    assign rdy[0]    = !valid_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[1];
    assign out_data  = wt_reg;

    // Stage 1: clamp and dead zone
    always_comb
    begin
        logic signed [fac_pkg::X_W:0] x_ext;
        logic signed [fac_pkg::X_W:0] lim_pos;
        logic signed [fac_pkg::X_W:0] lim_neg;
        logic signed [fac_pkg::X_W:0] clamp_v;
        logic [fac_pkg::CFG_W-1:0]    mag;

        x_ext   = (fac_pkg::X_W + 1)'(in_x);
        lim_pos = $signed({{(fac_pkg::X_W + 1 - fac_pkg::CFG_W){1'b0}}, cfg.input_limit});
        lim_neg = -lim_pos;
        if (x_ext > lim_pos)
        begin
            clamp_v = lim_pos;
        end
        else if (x_ext < lim_neg)
        begin
            clamp_v = lim_neg;
        end
        else
        begin
            clamp_v = x_ext;
        end
        x_next       = fac_pkg::COORD_W'(clamp_v);
        mag          = x_next[fac_pkg::COORD_W-1] ? fac_pkg::CFG_W'(-x_next)
                                                  : fac_pkg::CFG_W'(x_next);
        aligned_next = (mag < cfg.dead_zone);
    end

    // Stage 2: weight = triangle half span - |x - centre|, floored at zero
    always_comb
    begin
        int                                 kabs;
        logic [fac_pkg::DIST_W-1:0]         cmag;
        logic signed [fac_pkg::SD_W-1:0]    xe;
        logic signed [fac_pkg::SD_W-1:0]    ce;
        logic signed [fac_pkg::SD_W-1:0]    df;
        logic [fac_pkg::DIST_W-1:0]         gap;
        logic [fac_pkg::DIST_W-1:0]         hw;

        xe = fac_pkg::SD_W'(x_reg);
        hw = fac_pkg::DIST_W'(cfg.tri_half);
        wt_next.aligned = aligned_reg;
        for (int j = 0; j < fac_pkg::SET_CNT; j++)
        begin
            kabs = (j < fac_pkg::HALF_SETS) ? (fac_pkg::HALF_SETS - j) : (j - fac_pkg::HALF_SETS);
            cmag = fac_pkg::DIST_W'(int'(cfg.center_step) * kabs);
            ce   = (j < fac_pkg::HALF_SETS) ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
            df   = xe - ce;
            gap  = df[fac_pkg::SD_W-1] ? fac_pkg::DIST_W'(-df) : fac_pkg::DIST_W'(df);
            wt_next.w[j] = (hw > gap) ? fac_pkg::W_W'(hw - gap) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            x_reg       <= x_next;
            aligned_reg <= aligned_next;
        end
        if (rdy[1] && valid_reg[0])
        begin
            wt_reg <= wt_next;
        end
    end

endmodule

/* sv/fac_accum.sv */
// Middle pipeline: weight times singleton, side sums, signed difference.
// Three register stages; depends on fac_pkg.
`timescale 1ns / 1ps

module fac_accum
(
    input  logic          clk,
    input  logic          rst_n,
    input  fac_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  fac_pkg::wt_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fac_pkg::acc_t out_data
);

    localparam int H = fac_pkg::HALF_SETS;

    logic [2:0] valid_reg;
    logic [3:0] rdy;

    // Stage 3
    logic [H-1:0][fac_pkg::PROD_W-1:0] lprod_reg;
    logic [H-1:0][fac_pkg::PROD_W-1:0] lprod_next;
    logic [H-1:0][fac_pkg::PROD_W-1:0] rprod_reg;
    logic [H-1:0][fac_pkg::PROD_W-1:0] rprod_next;
    logic [fac_pkg::DEN_W-1:0]         den3_reg;
    logic [fac_pkg::DEN_W-1:0]         den3_next;
    logic                              al3_reg;

    // Stage 4
    logic [fac_pkg::SIDE_W-1:0] suml_reg;
    logic [fac_pkg::SIDE_W-1:0] suml_next;
    logic [fac_pkg::SIDE_W-1:0] sumr_reg;
    logic [fac_pkg::SIDE_W-1:0] sumr_next;
    logic [fac_pkg::DEN_W-1:0]  den4_reg;
    logic                       al4_reg;

    // Stage 5
    fac_pkg::acc_t acc_reg;
    fac_pkg::acc_t acc_next;

    function automatic logic [fac_pkg::SPD_W-1:0] singleton(input fac_pkg::cfg_t c,
                                                            input int kabs);
        priority if (kabs == 1)
        begin
            return c.out_small;
        end
        else if (kabs == 2)
        begin
            return c.out_medium;
        end
        else
        begin
            return c.out_big;
        end
    endfunction

    assign rdy[3]    = out_ready;
    assign rdy[2]    = !valid_reg[2] || rdy[3];
    assign rdy[1]    = !valid_reg[1] || rdy[2];
    assign rdy[0]    = !valid_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[2];
    assign out_data  = acc_reg;

    // Left sets turn positive, right sets negative; the centre set adds weight only
    always_comb
    begin
        for (int i = 0; i < H; i++)
        begin
            lprod_next[i] = fac_pkg::PROD_W'(in_data.w[i])
                          * fac_pkg::PROD_W'(singleton(cfg, H - i));
            rprod_next[i] = fac_pkg::PROD_W'(in_data.w[H + 1 + i])
                          * fac_pkg::PROD_W'(singleton(cfg, i + 1));
        end
        den3_next = '0;
        for (int j = 0; j < fac_pkg::SET_CNT; j++)
        begin
            den3_next = den3_next + fac_pkg::DEN_W'(in_data.w[j]);
        end
    end

    always_comb
    begin
        suml_next = '0;
        sumr_next = '0;
        for (int i = 0; i < H; i++)
        begin
            suml_next = suml_next + fac_pkg::SIDE_W'(lprod_reg[i]);
            sumr_next = sumr_next + fac_pkg::SIDE_W'(rprod_reg[i]);
        end
    end

    always_comb
    begin
        acc_next.neg     = (sumr_reg > suml_reg);
        acc_next.mag     = acc_next.neg ? (sumr_reg - suml_reg) : (suml_reg - sumr_reg);
        acc_next.den     = den4_reg;
        acc_next.zero    = (den4_reg == '0);
        acc_next.aligned = al4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (rdy[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            lprod_reg <= lprod_next;
            rprod_reg <= rprod_next;
            den3_reg  <= den3_next;
            al3_reg   <= in_data.aligned;
        end
        if (rdy[1] && valid_reg[0])
        begin
            suml_reg <= suml_next;
            sumr_reg <= sumr_next;
            den4_reg <= den3_reg;
            al4_reg  <= al3_reg;
        end
        if (rdy[2] && valid_reg[1])
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* sv/fac_divider.sv */
// Pipelined restoring divider for the weighted mean, then sign, clamp and
// the output register. Depends on fac_pkg.
`timescale 1ns / 1ps

module fac_divider
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  fac_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  fac_pkg::acc_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [fac_pkg::RATE_W-1:0]  out_rate,
    output logic                               out_aligned
);

    localparam int NST = fac_pkg::DIV_STAGES;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   vld_ext;
    logic [NST:0]   rdy_ext;

    fac_pkg::div_t entry;
    fac_pkg::div_t stage_in   [NST];
    fac_pkg::div_t stage_next [NST];
    fac_pkg::div_t stage_reg  [NST];

    logic                              out_valid_reg;
    logic signed [fac_pkg::RATE_W-1:0] rate_reg;
    logic signed [fac_pkg::RATE_W-1:0] rate_next;
    logic                              aligned_reg;

    assign vld_ext = {valid_reg, in_valid};
    assign rdy_ext[NST] = !out_valid_reg || out_ready;
    assign in_ready    = rdy_ext[0];
    assign out_valid   = out_valid_reg;
    assign out_rate    = rate_reg;
    assign out_aligned = aligned_reg;

    // The quotient fits Q_W bits, so the high part of the dividend already
    // lies below the divisor and seeds the remainder.
    always_comb
    begin
        entry.rem     = fac_pkg::DEN_W'(in_data.mag >> fac_pkg::Q_W);
        entry.low     = in_data.mag[fac_pkg::Q_W-1:0];
        entry.quo     = '0;
        entry.den     = in_data.den;
        entry.neg     = in_data.neg;
        entry.zero    = in_data.zero;
        entry.aligned = in_data.aligned;
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        assign rdy_ext[s] = !valid_reg[s] || rdy_ext[s + 1];

        if (s == 0)
        begin : g_first
            assign stage_in[s] = entry;
        end
        else
        begin : g_rest
            assign stage_in[s] = stage_reg[s - 1];
        end

        always_comb
        begin
            fac_pkg::div_t            t;
            logic [fac_pkg::DEN_W:0]  r2;

            t = stage_in[s];
            for (int i = 0; i < fac_pkg::DIV_STEPS; i++)
            begin
                r2    = {t.rem, t.low[fac_pkg::Q_W-1]};
                t.low = t.low << 1;
                if (r2 >= {1'b0, t.den})
                begin
                    t.rem = fac_pkg::DEN_W'(r2 - {1'b0, t.den});
                    t.quo = {t.quo[fac_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    t.rem = fac_pkg::DEN_W'(r2);
                    t.quo = {t.quo[fac_pkg::Q_W-2:0], 1'b0};
                end
            end
            stage_next[s] = t;
        end

        always_ff @(posedge clk)
        begin
            if (rdy_ext[s] && vld_ext[s])
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    // Truncation toward zero: divide magnitudes, then apply the sign
    always_comb
    begin
        fac_pkg::div_t              last;
        logic [fac_pkg::Q_W-1:0]    qc;

        last = stage_reg[NST - 1];
        qc   = (last.quo > cfg.max_speed) ? cfg.max_speed : last.quo;
        if (last.zero || last.aligned)
        begin
            rate_next = '0;
        end
        else if (last.neg)
        begin
            rate_next = -$signed(fac_pkg::RATE_W'(qc));
        end
        else
        begin
            rate_next = $signed(fac_pkg::RATE_W'(qc));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy_ext[i])
                begin
                    valid_reg[i] <= vld_ext[i];
                end
            end
            if (rdy_ext[NST])
            begin
                out_valid_reg <= valid_reg[NST - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_ext[NST] && valid_reg[NST - 1])
        begin
            rate_reg    <= rate_next;
            aligned_reg <= stage_reg[NST - 1].aligned;
        end
    end

endmodule
